>>> hdl/sorted_name_table_lookup_defines.svh
// assertion macros shared by the sorted name table modules
`ifndef SORTED_NAME_TABLE_LOOKUP_DEFINES_SVH
`define SORTED_NAME_TABLE_LOOKUP_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define SNTL_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define SNTL_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sntl_pkg.sv
// shared types, codes and constants of the sorted name table
package sntl_pkg;

  localparam int ENTRIES_DEF      = 32;
  localparam int NAME_BYTES_DEF   = 8;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int KEY_BITS      = 64;
  localparam int PAYLOAD_PORT  = 32;
  localparam int PLEN_BITS     = 4;
  localparam int CMD_BITS      = 2;
  localparam int STATUS_BITS   = 3;
  localparam int INDEX_BITS    = 5;
  localparam int TOTAL_BITS    = 6;
  localparam int IN_DATA_BITS  = 136;
  localparam int OUT_DATA_BITS = 144;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FIND   = 2'd1,
    OP_PREFIX = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_AMBIGUOUS = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    RD_MID,
    RD_PTR_M1,
    RD_PTR_M2,
    RD_IDX_M1,
    RD_IDX_P1,
    RD_IDX
  } rd_sel_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_RD,
    SRC_IN
  } out_src_t;

  typedef struct packed {
    logic     ld_in;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     set_mid;
    logic     lo_up;
    logic     hx_dn;
    logic     set_ins;
    logic     wr_shift;
    logic     wr_entry;
    logic     inc_count;
    logic     ld_out;
    status_t  out_status;
    out_src_t out_src;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       key_empty;
    logic       range_empty;
    logic       cmp_lt;
    logic       cmp_eq;
    logic       full;
    logic       ptr_gt_lo;
    logic       shift_more;
    logic       idx_gt0;
    logic       idx_nxt_valid;
  } dp_stat_t;

endpackage

>>> hdl/sntl_datapath.sv
// table memory, search bounds, shift pointer, compare and result registers
`include "sorted_name_table_lookup_defines.svh"

module sntl_datapath
  import sntl_pkg::*;
#(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int NAME_BYTES   = NAME_BYTES_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_cmd_t                cmd,
  output dp_stat_t                stat,
  input  logic [CMD_BITS-1:0]     in_command,
  input  logic [KEY_BITS-1:0]     in_key,
  input  logic [PLEN_BITS-1:0]    in_prefix_len,
  input  logic [PAYLOAD_PORT-1:0] in_handler,
  input  logic [PAYLOAD_PORT-1:0] in_extra,
  output logic [STATUS_BITS-1:0]  out_status,
  output logic [INDEX_BITS-1:0]   out_index,
  output logic [KEY_BITS-1:0]     out_name,
  output logic [PAYLOAD_PORT-1:0] out_handler,
  output logic [PAYLOAD_PORT-1:0] out_extra,
  output logic [TOTAL_BITS-1:0]   out_total
);

  localparam int NW = NAME_BYTES * 8;
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = (PAYLOAD_BITS < PAYLOAD_PORT) ? PAYLOAD_BITS : PAYLOAD_PORT;
  localparam int RW = NW + 2 * SW;

  logic [RW-1:0] mem [ENTRIES];
  logic [RW-1:0] rd_data;

  logic [NW-1:0] key;
  logic [NW-1:0] mask;
  logic [1:0]    op;
  logic [SW-1:0] hdl;
  logic [SW-1:0] ext;
  logic [CW-1:0] count;
  logic [CW-1:0] lo;
  logic [CW-1:0] hx;
  logic [CW-1:0] ptr;
  logic [IW-1:0] idx;

  logic [NW-1:0]        key_norm;
  logic [NW-1:0]        mask_next;
  logic                 run;
  logic [7:0]           byte_v;
  logic [PLEN_BITS-1:0] plen_c;
  logic [CW:0]          mid_sum;
  logic [IW-1:0]        mid;
  logic [CW-1:0]        ptr_m1;
  logic [CW-1:0]        ptr_m2;
  logic [CW-1:0]        idx_w;
  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        wr_addr;
  logic [RW-1:0]        wr_data;
  logic [NW-1:0]        rd_name;
  logic [SW-1:0]        rd_hdl;
  logic [SW-1:0]        rd_ext;
  logic [NW-1:0]        sel_name;
  logic [SW-1:0]        sel_hdl;
  logic [SW-1:0]        sel_ext;
  logic [NW+KEY_BITS-1:0]       name_ext;
  logic [SW+PAYLOAD_PORT-1:0]   hdl_ext;
  logic [SW+PAYLOAD_PORT-1:0]   ext_ext;
  logic [IW+INDEX_BITS-1:0]     idx_ext;
  logic [CW+TOTAL_BITS-1:0]     cnt_ext;

  // cut the key at its first zero byte
  always_comb begin
    run      = 1'b1;
    byte_v   = 8'h00;
    key_norm = '0;
    for (int b = NAME_BYTES - 1; b >= 0; b--) begin
      byte_v = in_key[8*b +: 8];
      run    = run & (byte_v != 8'h00);
      key_norm[8*b +: 8] = run ? byte_v : 8'h00;
    end
  end

  // keep the leading prefix bytes for prefix search, all bytes otherwise
  always_comb begin
    if (in_prefix_len == '0) begin
      plen_c = PLEN_BITS'(1);
    end else if (in_prefix_len > PLEN_BITS'(NAME_BYTES)) begin
      plen_c = PLEN_BITS'(NAME_BYTES);
    end else begin
      plen_c = in_prefix_len;
    end
    mask_next = '1;
    if (in_command == OP_PREFIX) begin
      for (int b = 0; b < NAME_BYTES; b++) begin
        mask_next[8*b +: 8] = ((b + int'(plen_c)) >= NAME_BYTES) ? 8'hFF : 8'h00;
      end
    end
  end

  assign mid_sum = {1'b0, lo} + {1'b0, hx} - (CW+1)'(1);
  assign mid     = mid_sum[IW:1];
  assign ptr_m1  = ptr - CW'(1);
  assign ptr_m2  = ptr - CW'(2);
  assign idx_w   = CW'(idx);

  always_comb begin
    case (cmd.rd_sel)
      RD_MID:    rd_addr = mid;
      RD_PTR_M1: rd_addr = ptr_m1[IW-1:0];
      RD_PTR_M2: rd_addr = ptr_m2[IW-1:0];
      RD_IDX_M1: rd_addr = idx - IW'(1);
      RD_IDX_P1: rd_addr = idx + IW'(1);
      RD_IDX:    rd_addr = idx;
      default:   rd_addr = idx;
    endcase
  end

  always_comb begin
    if (cmd.wr_shift) begin
      wr_addr = ptr[IW-1:0];
      wr_data = rd_data;
    end else begin
      wr_addr = idx;
      wr_data = {key, hdl, ext};
    end
  end

  assign rd_name = rd_data[RW-1 -: NW];
  assign rd_hdl  = rd_data[2*SW-1 -: SW];
  assign rd_ext  = rd_data[SW-1:0];

  assign stat.op            = op;
  assign stat.key_empty     = (key == '0);
  assign stat.range_empty   = (lo >= hx);
  assign stat.cmp_lt        = ((rd_name & mask) < (key & mask));
  assign stat.cmp_eq        = ((rd_name & mask) == (key & mask));
  assign stat.full          = (count >= CW'(ENTRIES));
  assign stat.ptr_gt_lo     = (ptr > lo);
  assign stat.shift_more    = ({1'b0, ptr} > ({1'b0, lo} + (CW+1)'(1)));
  assign stat.idx_gt0       = (idx != '0);
  assign stat.idx_nxt_valid = (({1'b0, idx_w} + (CW+1)'(1)) < {1'b0, count});

  always_ff @(posedge clk) begin
    if (cmd.wr_shift || cmd.wr_entry) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.inc_count) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      key  <= key_norm;
      mask <= mask_next;
      op   <= in_command;
      hdl  <= in_handler[SW-1:0];
      ext  <= in_extra[SW-1:0];
      lo   <= '0;
      hx   <= count;
    end
    if (cmd.set_mid) begin
      idx <= mid;
    end
    if (cmd.lo_up) begin
      lo <= idx_w + CW'(1);
    end
    if (cmd.hx_dn) begin
      hx <= idx_w;
    end
    if (cmd.set_ins) begin
      idx <= lo[IW-1:0];
      ptr <= count;
    end else if (cmd.wr_shift) begin
      ptr <= ptr_m1;
    end
  end

  // result fields, zero where the step found nothing
  always_comb begin
    case (cmd.out_src)
      SRC_RD: begin
        sel_name = rd_name;
        sel_hdl  = rd_hdl;
        sel_ext  = rd_ext;
      end
      SRC_IN: begin
        sel_name = key;
        sel_hdl  = hdl;
        sel_ext  = ext;
      end
      default: begin
        sel_name = '0;
        sel_hdl  = '0;
        sel_ext  = '0;
      end
    endcase
  end

  assign name_ext = {{KEY_BITS{1'b0}}, sel_name};
  assign hdl_ext  = {{PAYLOAD_PORT{1'b0}}, sel_hdl};
  assign ext_ext  = {{PAYLOAD_PORT{1'b0}}, sel_ext};
  assign idx_ext  = {{INDEX_BITS{1'b0}}, idx};
  assign cnt_ext  = {{TOTAL_BITS{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_status  <= cmd.out_status;
      out_index   <= (cmd.out_src == SRC_NONE) ? '0 : idx_ext[INDEX_BITS-1:0];
      out_name    <= name_ext[KEY_BITS-1:0];
      out_handler <= hdl_ext[PAYLOAD_PORT-1:0];
      out_extra   <= ext_ext[PAYLOAD_PORT-1:0];
      out_total   <= cnt_ext[TOTAL_BITS-1:0];
    end
  end

  `SNTL_IMPLIES(a_count_range, 1'b1, count <= CW'(ENTRIES), "entry count above table size")
  `SNTL_IMPLIES(a_shift_bound, cmd.wr_shift, ptr > lo, "shift write below insert point")

endmodule

>>> hdl/sntl_controller.sv
// sequencer for search, insert shift, neighbour checks and result hand-off
`include "sorted_name_table_lookup_defines.svh"

module sntl_controller
  import sntl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SEARCH,
    S_COMPARE,
    S_SHIFT_PRIME,
    S_SHIFT_MOVE,
    S_INSERT,
    S_REPLACE,
    S_NBR_L,
    S_NBR_L_CHK,
    S_NBR_R,
    S_NBR_R_CHK,
    S_FETCH,
    S_LOAD
  } state_t;

  state_t   state;
  state_t   state_next;
  status_t  res_code;
  status_t  res_code_next;
  out_src_t res_src;
  out_src_t res_src_next;

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = RD_IDX;
    cmd.out_status = res_code;
    cmd.out_src    = res_src;
    in_ready       = 1'b0;
    state_next     = state;
    res_code_next  = res_code;
    res_src_next   = res_src;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_in  = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.key_empty) begin
          res_code_next = ST_EMPTY;
          res_src_next  = SRC_NONE;
          state_next    = S_LOAD;
        end else begin
          case (stat.op)
            OP_ADD, OP_FIND, OP_PREFIX: state_next = S_SEARCH;
            default: begin
              res_code_next = ST_NOT_FOUND;
              res_src_next  = SRC_NONE;
              state_next    = S_LOAD;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (stat.range_empty) begin
          res_src_next = SRC_NONE;
          if (stat.op != OP_ADD) begin
            res_code_next = ST_NOT_FOUND;
            state_next    = S_LOAD;
          end else if (stat.full) begin
            res_code_next = ST_FULL;
            state_next    = S_LOAD;
          end else begin
            cmd.set_ins = 1'b1;
            state_next  = S_SHIFT_PRIME;
          end
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_MID;
          cmd.set_mid = 1'b1;
          state_next  = S_COMPARE;
        end
      end
      S_COMPARE: begin
        if (stat.cmp_eq) begin
          case (stat.op)
            OP_ADD:    state_next = S_REPLACE;
            OP_PREFIX: state_next = S_NBR_L;
            default: begin
              res_code_next = ST_OK;
              res_src_next  = SRC_RD;
              state_next    = S_LOAD;
            end
          endcase
        end else if (stat.cmp_lt) begin
          cmd.lo_up  = 1'b1;
          state_next = S_SEARCH;
        end else begin
          cmd.hx_dn  = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SHIFT_PRIME: begin
        if (stat.ptr_gt_lo) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_M1;
          state_next = S_SHIFT_MOVE;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_SHIFT_MOVE: begin
        // write one entry up while the next one below is read
        cmd.wr_shift = 1'b1;
        if (stat.shift_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_M2;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.wr_entry  = 1'b1;
        cmd.inc_count = 1'b1;
        res_code_next = ST_OK;
        res_src_next  = SRC_IN;
        state_next    = S_LOAD;
      end
      S_REPLACE: begin
        cmd.wr_entry  = 1'b1;
        res_code_next = ST_OK;
        res_src_next  = SRC_IN;
        state_next    = S_LOAD;
      end
      S_NBR_L: begin
        if (stat.idx_gt0) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
          state_next = S_NBR_L_CHK;
        end else begin
          state_next = S_NBR_R;
        end
      end
      S_NBR_L_CHK: begin
        if (stat.cmp_eq) begin
          res_code_next = ST_AMBIGUOUS;
          res_src_next  = SRC_NONE;
          state_next    = S_LOAD;
        end else begin
          state_next = S_NBR_R;
        end
      end
      S_NBR_R: begin
        if (stat.idx_nxt_valid) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_P1;
          state_next = S_NBR_R_CHK;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_NBR_R_CHK: begin
        if (stat.cmp_eq) begin
          res_code_next = ST_AMBIGUOUS;
          res_src_next  = SRC_NONE;
          state_next    = S_LOAD;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_IDX;
        res_code_next = ST_OK;
        res_src_next  = SRC_RD;
        state_next    = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid || out_ready) begin
          cmd.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_code  <= ST_OK;
      res_src   <= SRC_NONE;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
      res_src  <= res_src_next;
      if (cmd.ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SNTL_IMPLIES(a_load_free, cmd.ld_out, !out_valid || out_ready, "result overwritten")
  `SNTL_NEXT(a_load_shows, cmd.ld_out, out_valid, "loaded result not presented")
  `SNTL_IMPLIES(a_grow_room, cmd.inc_count, !stat.full, "insert into a full table")
  `SNTL_IMPLIES(a_one_write, cmd.wr_shift, !cmd.wr_entry, "two writes in one cycle")

endmodule

>>> hdl/sorted_name_table_lookup.sv
// top level of the sorted name table with exact and unique-prefix lookup
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   command, key, prefix length, payload words
// m_*       out  m_tvalid/m_tready   status, index, name, payload words, total
//
// per item: the item is taken and decoded, then the registered table read is probed
// (at most clog2(ENTRIES+1) probes) and the range closes on a miss; an insert
// then moves the entries up one by one, a replace writes in place, and a prefix
// hit runs the neighbour checks and a final read; last the result is loaded
// rst clears the entry count and the controller; the table needs no clearing
// a new item is taken while a result waits; it stalls only at its own hand-off

module sorted_name_table_lookup
  import sntl_pkg::*;
#(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int NAME_BYTES   = NAME_BYTES_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // command[1:0], key_name[65:2], prefix_len[69:66], handler_id[101:70],
  // extra_ref[133:102], zero pad[135:134]
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // status[2:0], entry_index[7:3], matched_name[71:8], handler_out[103:72],
  // extra_out[135:104], entry_total[141:136], zero pad[143:142]
  output logic [OUT_DATA_BITS-1:0] m_tdata
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  logic [STATUS_BITS-1:0]  status;
  logic [INDEX_BITS-1:0]   entry_index;
  logic [KEY_BITS-1:0]     matched_name;
  logic [PAYLOAD_PORT-1:0] handler_out;
  logic [PAYLOAD_PORT-1:0] extra_out;
  logic [TOTAL_BITS-1:0]   entry_total;

  // sequencer: owns both handshakes and drives the datapath
  sntl_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table memory, search bounds and result registers
  sntl_datapath #(
    .ENTRIES      (ENTRIES),
    .NAME_BYTES   (NAME_BYTES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_command    (s_tdata[1:0]),
    .in_key        (s_tdata[65:2]),
    .in_prefix_len (s_tdata[69:66]),
    .in_handler    (s_tdata[101:70]),
    .in_extra      (s_tdata[133:102]),
    .out_status    (status),
    .out_index     (entry_index),
    .out_name      (matched_name),
    .out_handler   (handler_out),
    .out_extra     (extra_out),
    .out_total     (entry_total)
  );

  // result item packed lowest field first, padded to whole bytes
  assign m_tdata = {2'b00, entry_total, extra_out, handler_out, matched_name,
                    entry_index, status};

endmodule

>>> dv/tb_sorted_name_table_lookup.sv
// self-checking testbench for the sorted name table: add, exact search and unique prefix search
module tb_sorted_name_table_lookup
  import sntl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // table depth and name width of the block as built with its defaults
  localparam int TABLE_DEPTH = ENTRIES_DEF;
  localparam int NAME_LEN    = NAME_BYTES_DEF;
  // command code the block does not use; it must answer not found for a non-empty name
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // generous cycle budget for ~575 items, many times over
  localparam int CYCLE_LIMIT = 500000;
  // quiet cycles after the last result
  localparam int SETTLE_CYCLES = 120;

  // one command as sent to the block
  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [3:0]  plen;
    logic [31:0] handler;
    logic [31:0] extra;
  } name_cmd_t;

  // one answer from the block
  typedef struct {
    logic [2:0]  status;
    logic [4:0]  index;
    logic [63:0] name;
    logic [31:0] handler;
    logic [31:0] extra;
    logic [5:0]  total;
  } name_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;

  sorted_name_table_lookup uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // commands waiting to be driven, answers the table should still give
  name_cmd_t   queued_cmds[$];
  name_reply_t awaited_replies[$];
  // names handed to add commands, reused to hit stored entries
  logic [63:0] name_pool[$];

  // shadow copy of the table, kept in sorted order
  logic [63:0] shadow_name[TABLE_DEPTH];
  logic [31:0] shadow_handler[TABLE_DEPTH];
  logic [31:0] shadow_extra[TABLE_DEPTH];
  int          shadow_count = 0;

  int  mismatches = 0;
  int  cycle_count = 0;
  int  status_seen[5] = '{default: 0};
  bit  all_loaded = 1'b0;
  int  send_gap = 0;
  int  recv_stall = 0;
  name_cmd_t cur_cmd;

  // ---------------------------------------------------------------------------
  // shadow table
  // ---------------------------------------------------------------------------

  // a name ends at its first zero byte; everything after it is cleared
  function automatic logic [63:0] trim_name(input logic [63:0] key);
    logic [63:0] r;
    bit          stop;
    r = '0;
    stop = 1'b0;
    for (int i = NAME_LEN - 1; i >= 0; i--) begin
      if (!stop) begin
        if (key[8*i +: 8] == 8'h00) stop = 1'b1;
        else r[8*i +: 8] = key[8*i +: 8];
      end
    end
    return r;
  endfunction

  // binary search on the leading plen bytes; probe index on a hit, else -1,
  // with pos left at the lower bound for an insert
  function automatic int locate(input logic [63:0] key, input int plen, output int pos);
    int          shift;
    int          lo;
    int          hi;
    int          mid;
    logic [63:0] k;
    logic [63:0] s;
    shift = 8 * (NAME_LEN - plen);
    k = key >> shift;
    lo = 0;
    hi = shadow_count - 1;
    while (hi >= lo) begin
      mid = (lo + hi) / 2;
      s = shadow_name[mid] >> shift;
      if (s < k) begin
        lo = mid + 1;
      end else if (s > k) begin
        hi = mid - 1;
      end else begin
        pos = mid;
        return mid;
      end
    end
    pos = lo;
    return -1;
  endfunction

  // runs one command against the shadow table and returns the answer it gives
  function automatic name_reply_t apply_to_table(input name_cmd_t c);
    name_reply_t rep;
    logic [63:0] key;
    logic [63:0] k;
    int          plen;
    int          shift;
    int          found;
    int          pos;
    int          idx;
    bit          hit;
    bit          left;
    bit          right;
    key = trim_name(c.key);
    plen = c.plen;
    if (plen < 1) plen = 1;
    if (plen > NAME_LEN) plen = NAME_LEN;
    rep = '{status: ST_NOT_FOUND, index: '0, name: '0, handler: '0, extra: '0, total: '0};
    hit = 1'b0;
    idx = 0;
    pos = 0;

    if (key == '0) begin
      // empty name is refused whatever the command
      rep.status = ST_EMPTY;
    end else if (c.cmd == OP_ADD) begin
      found = locate(key, NAME_LEN, pos);
      if (found >= 0) begin
        // name already there: payload replaced in place
        idx = found;
        hit = 1'b1;
      end else if (shadow_count >= TABLE_DEPTH) begin
        rep.status = ST_FULL;
      end else begin
        // open a slot at the lower bound by moving the higher entries up
        for (int i = shadow_count; i > pos; i--) begin
          shadow_name[i]    = shadow_name[i-1];
          shadow_handler[i] = shadow_handler[i-1];
          shadow_extra[i]   = shadow_extra[i-1];
        end
        shadow_count++;
        idx = pos;
        hit = 1'b1;
      end
      if (hit) begin
        shadow_name[idx]    = key;
        shadow_handler[idx] = c.handler;
        shadow_extra[idx]   = c.extra;
      end
    end else if (c.cmd == OP_FIND) begin
      found = locate(key, NAME_LEN, pos);
      if (found >= 0) begin
        idx = found;
        hit = 1'b1;
      end
    end else if (c.cmd == OP_PREFIX) begin
      found = locate(key, plen, pos);
      if (found >= 0) begin
        // matches sit next to each other, so a neighbour match means ambiguity
        shift = 8 * (NAME_LEN - plen);
        k = key >> shift;
        left  = (found > 0) && ((shadow_name[found-1] >> shift) == k);
        right = (found + 1 < shadow_count) && ((shadow_name[found+1] >> shift) == k);
        if (left || right) begin
          rep.status = ST_AMBIGUOUS;
        end else begin
          idx = found;
          hit = 1'b1;
        end
      end
    end

    if (hit) begin
      rep.status  = ST_OK;
      rep.index   = idx[4:0];
      rep.name    = shadow_name[idx];
      rep.handler = shadow_handler[idx];
      rep.extra   = shadow_extra[idx];
    end
    rep.total = shadow_count[5:0];
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // ascii text to a packed name, first character in the top byte
  function automatic logic [63:0] pack_name(input string s);
    logic [63:0] n;
    n = '0;
    for (int i = 0; i < s.len() && i < NAME_LEN; i++) n[8*(NAME_LEN-1-i) +: 8] = s[i];
    return n;
  endfunction

  task automatic queue_cmd(input logic [1:0] cmd, input logic [63:0] key, input logic [3:0] plen,
                           input logic [31:0] handler, input logic [31:0] extra);
    name_cmd_t c;
    c = '{cmd: cmd, key: key, plen: plen, handler: handler, extra: extra};
    queued_cmds.push_back(c);
  endtask

  // mostly short lower-case names over a narrow alphabet so prefixes collide,
  // sometimes a fully random word with odd bytes and embedded zeros
  function automatic logic [63:0] fresh_name();
    logic [63:0] n;
    int          len;
    int          span;
    n = '0;
    if ($urandom_range(0, 3) != 0) begin
      len = $urandom_range(1, NAME_LEN);
      span = $urandom_range(1, 25);
      for (int i = 0; i < len; i++) n[8*(NAME_LEN-1-i) +: 8] = 8'h61 + 8'($urandom_range(0, span));
    end else begin
      n = {$urandom, $urandom};
    end
    return n;
  endfunction

  function automatic name_cmd_t random_cmd();
    name_cmd_t c;
    int        pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) c.cmd = OP_ADD;
    else if (pick < 13) c.cmd = OP_FIND;
    else if (pick < 19) c.cmd = OP_PREFIX;
    else c.cmd = OP_UNUSED;

    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      // empty key, either all zero or a zero first byte with junk behind it
      c.key = $urandom_range(0, 1) ? 64'h0 : {8'h00, 24'($urandom), $urandom};
    end else if (pick < 11 && name_pool.size() != 0) begin
      c.key = name_pool[$urandom_range(0, name_pool.size() - 1)];
    end else begin
      c.key = fresh_name();
    end
    if (c.cmd == OP_ADD) name_pool.push_back(trim_name(c.key));

    c.plen = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    c.handler = $urandom;
    c.extra = $urandom;
    return c;
  endfunction

  // the last few dozen items run with no idling on either side
  function automatic bit in_tail();
    return all_loaded && queued_cmds.size() < 40;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: one item in flight on the slave side, random gaps between items
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      // item taken: the shadow table answers it now, in acceptance order
      if (s_tvalid && s_tready) awaited_replies.push_back(apply_to_table(cur_cmd));

      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (queued_cmds.size() != 0 && !in_tail() && $urandom_range(0, 7) == 0) begin
          // idle burst between items
          send_gap = $urandom_range(0, 2);
          s_tvalid <= 1'b0;
        end else if (queued_cmds.size() != 0) begin
          cur_cmd = queued_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {2'b00, cur_cmd.extra, cur_cmd.handler, cur_cmd.plen, cur_cmd.key, cur_cmd.cmd};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each answer against the oldest awaited one, stalls at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    name_reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_replies.size() == 0) begin
          $error("answer 0x%0h arrived with no command outstanding", m_tdata);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("status", want.status, m_tdata[2:0]);
          check_field("entry_index", want.index, m_tdata[7:3]);
          check_field("matched_name", want.name, m_tdata[71:8]);
          check_field("handler_out", want.handler, m_tdata[103:72]);
          check_field("extra_out", want.extra, m_tdata[135:104]);
          check_field("entry_total", want.total, m_tdata[141:136]);
          if (want.status <= ST_EMPTY) status_seen[want.status]++;
        end
      end

      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
        // random stall burst
        recv_stall = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers still awaited",
               cycle_count, awaited_replies.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: directed checks, then two random phases with a full drain between
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty names, including a zero first byte with data behind it
    queue_cmd(OP_ADD, 64'h0, 4'd8, 32'h1234_5678, 32'h9abc_def0);
    queue_cmd(OP_FIND, 64'h00FF_FFFF_FFFF_FFFF, 4'd8, '0, '0);
    queue_cmd(OP_PREFIX, 64'h0, 4'd0, '0, '0);
    // lookups in an empty table
    queue_cmd(OP_FIND, pack_name("m"), 4'd8, '0, '0);
    queue_cmd(OP_PREFIX, pack_name("m"), 4'd1, '0, '0);
    // inserts at the front, middle and back, with payload extremes
    queue_cmd(OP_ADD, pack_name("m"), 4'd8, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_cmd(OP_ADD, pack_name("abc"), 4'd8, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_cmd(OP_ADD, pack_name("abd"), 4'd8, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    queue_cmd(OP_ADD, pack_name("ab"), 4'd8, 32'h0000_0001, 32'h8000_0000);
    queue_cmd(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h7FFF_FFFF, 32'h0000_0001);
    queue_cmd(OP_ADD, 64'h0100_0000_0000_0000, 4'd8, 32'h1111_1111, 32'h2222_2222);
    queue_cmd(OP_ADD, pack_name("zzzzzzzz"), 4'd8, 32'h3333_3333, 32'h4444_4444);
    // a zero byte mid-name cuts it back to "ab", so this replaces
    queue_cmd(OP_ADD, 64'h6162_0063_6400_0000, 4'd8, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    queue_cmd(OP_ADD, pack_name("abc"), 4'd8, 32'h0BAD_CAFE, 32'hFEED_FACE);
    // exact hit and near miss
    queue_cmd(OP_FIND, pack_name("abc"), 4'd8, '0, '0);
    queue_cmd(OP_FIND, pack_name("abcd"), 4'd8, '0, '0);
    // prefix: ambiguous, length 0 and over-long lengths clamped, short key padded with zeros
    queue_cmd(OP_PREFIX, pack_name("ab"), 4'd2, '0, '0);
    queue_cmd(OP_PREFIX, pack_name("m"), 4'd0, '0, '0);
    queue_cmd(OP_PREFIX, pack_name("zzzzzzzz"), 4'd15, '0, '0);
    queue_cmd(OP_PREFIX, pack_name("zz"), 4'd3, '0, '0);
    queue_cmd(OP_PREFIX, pack_name("abd"), 4'd3, '0, '0);
    queue_cmd(OP_UNUSED, pack_name("m"), 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(OP_PREFIX, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1, '0, '0);
    queue_cmd(OP_FIND, 64'h0100_0000_0000_0000, 4'd8, '0, '0);
    queue_cmd(OP_ADD, pack_name("q"), 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    name_pool = '{pack_name("m"), pack_name("abc"), pack_name("abd"), pack_name("ab"),
                  pack_name("zzzzzzzz"), pack_name("q")};

    for (int phase = 0; phase < 2; phase++) begin
      // hold off the sender until every answer so far is back
      while (queued_cmds.size() != 0 || s_tvalid || awaited_replies.size() != 0) @(negedge clk);
      for (int n = 0; n < 275; n++) queued_cmds.push_back(random_cmd());
    end
    all_loaded = 1'b1;

    while (queued_cmds.size() != 0 || s_tvalid || awaited_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("answers: %0d ok, %0d not found, %0d ambiguous, %0d full, %0d empty name",
             status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_AMBIGUOUS],
             status_seen[ST_FULL], status_seen[ST_EMPTY]);
    $display("table ended with %0d of %0d entries after %0d cycles",
             shadow_count, TABLE_DEPTH, cycle_count);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
